// ===== hdl/phc_pkg.sv =====
// Package with the shared types, register indexes and clamp function of the heater controller.
package phc_pkg;

    localparam int unsigned SAMPLE_W = 8;
    localparam int unsigned GAIN_W   = 16;
    localparam int unsigned LIMIT_W  = 16;
    localparam int unsigned INTEG_W  = 24;
    localparam int unsigned PROD_W   = GAIN_W + SAMPLE_W + 1;
    localparam int unsigned SUM_W    = 28;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_TEMP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LIMIT = 3'd4;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd255;

    typedef struct packed {
        logic signed [GAIN_W-1:0]   prop_gain;
        logic signed [GAIN_W-1:0]   integ_gain;
        logic signed [GAIN_W-1:0]   deriv_gain;
        logic        [SAMPLE_W-1:0] target_temp;
        logic        [LIMIT_W-1:0]  output_limit;
    } t_cfg;

    // Values above the limit become the limit; otherwise values below one become one.
    function automatic logic [INTEG_W-1:0] clamp_q8(
        input logic signed [SUM_W-1:0] v,
        input logic        [LIMIT_W-1:0] limit
    );
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] one;
        logic [INTEG_W-1:0]      res;
        hi  = $signed({4'b0000, limit, 8'h00});
        one = $signed(SUM_W'(256));
        if (v > hi) begin
            res = hi[INTEG_W-1:0];
        end else if (v < one) begin
            res = one[INTEG_W-1:0];
        end else begin
            res = v[INTEG_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== hdl/phc_core.sv =====
// Combinational control law: integrator update and drive computation for one sample.
module phc_core (
    input  phc_pkg::t_cfg                  i_cfg,
    input  logic [phc_pkg::SAMPLE_W-1:0]   i_sample,
    input  logic [phc_pkg::SAMPLE_W-1:0]   i_last_sample,
    input  logic [phc_pkg::INTEG_W-1:0]    i_integ,
    output logic [phc_pkg::INTEG_W-1:0]    o_integ_next,
    output logic [phc_pkg::LIMIT_W-1:0]    o_drive
);
    import phc_pkg::*;

    logic signed [SAMPLE_W:0]   err;
    logic signed [SAMPLE_W:0]   chg;
    logic signed [PROD_W-1:0]   prod_i;
    logic signed [PROD_W-1:0]   prod_p;
    logic signed [PROD_W-1:0]   prod_d;
    logic signed [SUM_W-1:0]    sum;
    logic signed [SUM_W-1:0]    drv;
    logic        [INTEG_W-1:0]  integ_next;
    logic        [INTEG_W-1:0]  drive_q;

    always_comb begin
        err    = $signed({1'b0, i_cfg.target_temp}) - $signed({1'b0, i_sample});
        chg    = $signed({1'b0, i_sample}) - $signed({1'b0, i_last_sample});
        prod_i = PROD_W'(i_cfg.integ_gain) * PROD_W'(err);
        prod_p = PROD_W'(i_cfg.prop_gain) * PROD_W'(chg);
        prod_d = PROD_W'(i_cfg.deriv_gain) * PROD_W'(chg);
        sum    = $signed({4'b0000, i_integ}) + SUM_W'(prod_i) - SUM_W'(prod_p);
        integ_next = clamp_q8(sum, i_cfg.output_limit);
        drv    = $signed({4'b0000, integ_next}) - SUM_W'(prod_d);
        drive_q = clamp_q8(drv, i_cfg.output_limit);
    end

    assign o_integ_next = integ_next;
    assign o_drive      = drive_q[INTEG_W-1:8];

endmodule

// ===== hdl/pid_heater_controller.sv =====
// Top level of the PID heater controller with proportional action on the measurement.
//
// Usage: each transaction on the input channel (i_in_valid / o_in_ready) carries one
// 8-bit temperature sample. Each sample produces exactly one transaction on the output
// channel (o_out_valid / i_out_ready) carrying a 16-bit drive level.
// The sample is captured in an input register at the accepting edge, and the control law
// is evaluated in one pass of combinational logic into the output register once that
// register is empty or its result is taken by the receiver.
// Throughput is one sample per cycle while the receiver does not stall; the parallel
// multiply, add and clamp pass between the two registers sets that figure.
// The integrator and previous sample update as each sample moves into the output
// register, so consecutive samples see the state left by the one before.
// Configuration is written through i_cfg_we, i_cfg_index and i_cfg_data; the user must do
// so only while the block is idle, as the block does not enforce it. Indexes 0 to 4 select
// the proportional, integral and derivative gains, the target temperature and the output
// limit. Other indexes are ignored. Reset clears the gains, target, integrator and previous
// sample, and sets the output limit to 255. When the receiver stalls, the output register
// holds and the input register fills; the input channel then stalls as well.
module pid_heater_controller (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [phc_pkg::SAMPLE_W-1:0]     i_temp_sample,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [phc_pkg::LIMIT_W-1:0]      o_drive_level,
    input  logic                             i_cfg_we,
    input  logic [phc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [phc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import phc_pkg::*;

    t_cfg                 r_cfg;
    t_cfg                 n_cfg;
    logic                 r_in_valid;
    logic [SAMPLE_W-1:0]  r_sample;
    logic                 r_out_valid;
    logic [LIMIT_W-1:0]   r_drive;
    logic [INTEG_W-1:0]   r_integ;
    logic [SAMPLE_W-1:0]  r_last_sample;
    logic [INTEG_W-1:0]   integ_next;
    logic [LIMIT_W-1:0]   drive_next;
    logic                 advance;
    logic                 in_ready;

    assign advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign in_ready = !r_in_valid || advance;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_PROP_GAIN:    n_cfg.prop_gain    = $signed(i_cfg_data[GAIN_W-1:0]);
                REG_INTEG_GAIN:   n_cfg.integ_gain   = $signed(i_cfg_data[GAIN_W-1:0]);
                REG_DERIV_GAIN:   n_cfg.deriv_gain   = $signed(i_cfg_data[GAIN_W-1:0]);
                REG_TARGET_TEMP:  n_cfg.target_temp  = i_cfg_data[SAMPLE_W-1:0];
                REG_OUTPUT_LIMIT: n_cfg.output_limit = i_cfg_data[LIMIT_W-1:0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    phc_core u_core (
        .i_cfg         (r_cfg),
        .i_sample      (r_sample),
        .i_last_sample (r_last_sample),
        .i_integ       (r_integ),
        .o_integ_next  (integ_next),
        .o_drive       (drive_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain    <= '0;
            r_cfg.integ_gain   <= '0;
            r_cfg.deriv_gain   <= '0;
            r_cfg.target_temp  <= '0;
            r_cfg.output_limit <= LIMIT_RESET;
            r_in_valid         <= 1'b0;
            r_out_valid        <= 1'b0;
            r_integ            <= '0;
            r_last_sample      <= '0;
        end else begin
            r_cfg <= n_cfg;
            if (in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid   <= 1'b1;
                r_integ       <= integ_next;
                r_last_sample <= r_sample;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in_valid) begin
            r_sample <= i_temp_sample;
        end
        if (advance) begin
            r_drive <= drive_next;
        end
    end

    assign o_in_ready    = in_ready;
    assign o_out_valid   = r_out_valid;
    assign o_drive_level = r_drive;

endmodule
